// File: hdl/osa_pkg.sv
// ----------------------------------------------------------------------------
// OSA edit distance package
// Shared constants for the edit distance engine, its memories and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package osa_pkg;

    // Default string capacity and stored character width.
    localparam int MAX_LEN_DEF   = 64;
    localparam int CHAR_BITS_DEF = 16;

    // Port widths fixed by the interface.
    localparam int CMD_W  = 2;
    localparam int CODE_W = 16;
    localparam int DIST_W = 7;

    // Largest distance the result port can carry.
    localparam int DIST_MAX = 127;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_APPEND_FIRST  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND_SECOND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COMPUTE       = 2'd2;

endpackage

`default_nettype wire

// File: hdl/osa_ram.sv
// ----------------------------------------------------------------------------
// OSA generic RAM
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module osa_ram #(
    parameter int WIDTH = osa_pkg::CHAR_BITS_DEF,
    parameter int DEPTH = osa_pkg::MAX_LEN_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // Read data holds between reads.
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: hdl/damerau_osa_edit_distance_top.sv
// ----------------------------------------------------------------------------
// Damerau OSA edit distance engine
// Loads two strings one character per word and returns their optimal string
// alignment (or plain Levenshtein) distance on a compute command.
// ----------------------------------------------------------------------------
//
// Channel    Direction  Handshake              Payload
// command    in         start / busy           i_command, i_char_code
// result     out        o_valid (one cycle)    o_distance, o_overflow
// config     in         i_cfg_valid / ready    i_cfg_data
//
// An append leaves busy low.
// A compute with rows = first length and cols = second length sweeps the
// matrix one cell per cycle, read from and written back to the row memory,
// with a row fetch state before each row to fetch the row character.
// With either string empty the result follows in the next cycle.
// Reset is synchronous, clears counts, flags and the sequencer, and sets the transposition enable.
// The result cannot be stalled; o_valid is high for exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module damerau_osa_edit_distance_top #(
    parameter int MAX_LEN   = osa_pkg::MAX_LEN_DEF,
    parameter int CHAR_BITS = osa_pkg::CHAR_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [osa_pkg::CMD_W-1:0]   i_command,
    input  wire logic [osa_pkg::CODE_W-1:0]  i_char_code,
    output logic                             o_valid,
    output logic      [osa_pkg::DIST_W-1:0]  o_distance,
    output logic                             o_overflow,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic                        i_cfg_data
);

    localparam int AW = $clog2(MAX_LEN);
    localparam int CW = $clog2(MAX_LEN + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_ROW  = 3'b010,
        S_CELL = 3'b100
    } t_state;

    t_state r_state;

    logic [CW-1:0] r_cnt_a;
    logic [CW-1:0] r_cnt_b;
    logic          r_drop;
    logic          r_allow;
    logic [CW-1:0] r_i;
    logic [CW-1:0] r_j;
    logic [CW-1:0] r_diag;
    logic [CW-1:0] r_left;
    logic [CW-1:0] r_tb1;
    logic [CW-1:0] r_tb2;
    logic [CHAR_BITS-1:0] r_b_prev;
    logic [CHAR_BITS-1:0] r_a_prev;
    logic                         r_valid;
    logic [osa_pkg::DIST_W-1:0]   r_dist;
    logic                         r_ovf;

    logic accept;
    logic we_a;
    logic we_b;
    logic re_b;
    logic [CHAR_BITS-1:0] wdata_code;
    logic [CHAR_BITS-1:0] rd_a;
    logic [CHAR_BITS-1:0] rd_b;
    logic [AW-1:0]        raddr_b;
    logic [CW-1:0]        i_m1;
    logic [CW-1:0]        j_m1;
    logic [2*CW-1:0]      rd_row;
    logic [2*CW-1:0]      wd_row;
    logic [CW-1:0]        prev_j;
    logic [CW-1:0]        tb_j;
    logic [CW:0]          c_sub;
    logic [CW:0]          c_ins;
    logic [CW:0]          c_del;
    logic [CW:0]          c_tr;
    logic [CW:0]          c_min;
    logic                 swap_hit;
    logic [CW-1:0]        n_cell;

    function automatic logic [osa_pkg::DIST_W-1:0] f_sat(input logic [CW-1:0] v);
        logic [CW+7:0] w;
        w = (CW+8)'(v);
        if (w > (CW+8)'(osa_pkg::DIST_MAX)) begin
            return osa_pkg::DIST_W'(osa_pkg::DIST_MAX);
        end
        return w[osa_pkg::DIST_W-1:0];
    endfunction

    assign busy        = (r_state != S_IDLE);
    assign accept      = start && !busy;
    assign o_cfg_ready = !busy;
    assign o_valid     = r_valid;
    assign o_distance  = r_dist;
    assign o_overflow  = r_ovf;

    assign wdata_code = CHAR_BITS'(i_char_code);
    assign we_a = accept && (i_command == osa_pkg::CMD_APPEND_FIRST)
                  && (r_cnt_a != CW'(MAX_LEN));
    assign we_b = accept && (i_command == osa_pkg::CMD_APPEND_SECOND)
                  && (r_cnt_b != CW'(MAX_LEN));

    assign i_m1 = r_i - CW'(1);
    assign j_m1 = r_j - CW'(1);

    // Row fetch reads the first column; each cell fetches the next column.
    assign re_b    = (r_state == S_ROW) || ((r_state == S_CELL) && (r_j != r_cnt_b));
    assign raddr_b = (r_state == S_ROW) ? '0 : r_j[AW-1:0];

    osa_ram #(
        .WIDTH (CHAR_BITS),
        .DEPTH (MAX_LEN)
    ) u_text_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (r_cnt_a[AW-1:0]),
        .i_wdata (wdata_code),
        .i_re    (r_state == S_ROW),
        .i_raddr (i_m1[AW-1:0]),
        .o_rdata (rd_a)
    );

    osa_ram #(
        .WIDTH (CHAR_BITS),
        .DEPTH (MAX_LEN)
    ) u_text_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (r_cnt_b[AW-1:0]),
        .i_wdata (wdata_code),
        .i_re    (re_b),
        .i_raddr (raddr_b),
        .o_rdata (rd_b)
    );

    // Entry j-1 holds {previous row, row before that} for column j.
    osa_ram #(
        .WIDTH (2 * CW),
        .DEPTH (MAX_LEN)
    ) u_rows (
        .i_clk   (i_clk),
        .i_we    (r_state == S_CELL),
        .i_waddr (j_m1[AW-1:0]),
        .i_wdata (wd_row),
        .i_re    (re_b),
        .i_raddr (raddr_b),
        .o_rdata (rd_row)
    );

    // On the first row the previous row is the column index itself.
    assign prev_j = (r_i == CW'(1)) ? r_j : rd_row[2*CW-1:CW];
    assign tb_j   = rd_row[CW-1:0];

    always_comb begin
        c_sub = {1'b0, r_diag} + ((rd_a != rd_b) ? (CW+1)'(1) : '0);
        c_ins = {1'b0, r_left} + (CW+1)'(1);
        c_del = {1'b0, prev_j} + (CW+1)'(1);
        c_tr  = {1'b0, r_tb2} + (CW+1)'(1);
        swap_hit = r_allow && (r_i != CW'(1)) && (r_j != CW'(1))
                   && (rd_a == r_b_prev) && (r_a_prev == rd_b);
        c_min = c_sub;
        if (c_ins < c_min) begin
            c_min = c_ins;
        end
        if (c_del < c_min) begin
            c_min = c_del;
        end
        if (swap_hit && (c_tr < c_min)) begin
            c_min = c_tr;
        end
        n_cell = c_min[CW-1:0];
    end

    assign wd_row = {n_cell, prev_j};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt_a <= '0;
            r_cnt_b <= '0;
            r_drop  <= 1'b0;
            r_allow <= 1'b1;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                r_allow <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        case (i_command)
                            osa_pkg::CMD_APPEND_FIRST: begin
                                if (we_a) begin
                                    r_cnt_a <= r_cnt_a + CW'(1);
                                end else begin
                                    r_drop <= 1'b1;
                                end
                            end
                            osa_pkg::CMD_APPEND_SECOND: begin
                                if (we_b) begin
                                    r_cnt_b <= r_cnt_b + CW'(1);
                                end else begin
                                    r_drop <= 1'b1;
                                end
                            end
                            osa_pkg::CMD_COMPUTE: begin
                                if ((r_cnt_a == '0) || (r_cnt_b == '0)) begin
                                    // An empty string leaves the other's length.
                                    r_valid <= 1'b1;
                                    r_dist  <= f_sat((r_cnt_a == '0) ? r_cnt_b : r_cnt_a);
                                    r_ovf   <= r_drop;
                                    r_cnt_a <= '0;
                                    r_cnt_b <= '0;
                                    r_drop  <= 1'b0;
                                end else begin
                                    r_i     <= CW'(1);
                                    r_state <= S_ROW;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_ROW: begin
                    r_j      <= CW'(1);
                    r_diag   <= i_m1;
                    r_left   <= r_i;
                    r_tb1    <= r_i - CW'(2);
                    // The read data still holds the previous row's character.
                    r_a_prev <= rd_a;
                    r_state  <= S_CELL;
                end
                S_CELL: begin
                    r_diag   <= prev_j;
                    r_left   <= n_cell;
                    r_tb2    <= r_tb1;
                    r_tb1    <= tb_j;
                    r_b_prev <= rd_b;
                    if (r_j != r_cnt_b) begin
                        r_j <= r_j + CW'(1);
                    end else if (r_i != r_cnt_a) begin
                        r_i     <= r_i + CW'(1);
                        r_state <= S_ROW;
                    end else begin
                        r_valid <= 1'b1;
                        r_dist  <= f_sat(n_cell);
                        r_ovf   <= r_drop;
                        r_cnt_a <= '0;
                        r_cnt_b <= '0;
                        r_drop  <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: hdl/osa_chk.sv
// ----------------------------------------------------------------------------
// OSA edit distance port checker
// Watches the engine's ports and flags sequencing errors between channels.
// ----------------------------------------------------------------------------
`default_nettype none

module osa_chk (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        start,
    input wire logic                        busy,
    input wire logic [osa_pkg::CMD_W-1:0]   i_command,
    input wire logic                        o_valid,
    input wire logic                        i_cfg_valid,
    input wire logic                        o_cfg_ready
);

    // A result appears only while the engine is idle.
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // An accepted compute either starts the sweep or answers at once.
    a_compute_reacts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_command == osa_pkg::CMD_COMPUTE)) |=> (busy || o_valid))
        else $error("compute accepted without reaction");

    // Appends never produce a result.
    a_append_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_command == osa_pkg::CMD_APPEND_FIRST ||
                            i_command == osa_pkg::CMD_APPEND_SECOND)) |=> !o_valid)
        else $error("result after append");

    // The engine only becomes busy after an accepted compute.
    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start && (i_command == osa_pkg::CMD_COMPUTE)))
        else $error("busy without compute");

    // Configuration is only taken while idle.
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready) |-> !busy)
        else $error("configuration write while busy");

endmodule

bind damerau_osa_edit_distance_top osa_chk u_osa_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_command   (i_command),
    .o_valid     (o_valid),
    .i_cfg_valid (i_cfg_valid),
    .o_cfg_ready (o_cfg_ready)
);

`default_nettype wire
